// ===== rtl/note_sequence_tone_synth_macros.svh =====
// Assertion macros for the tone synthesizer.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef NOTE_SEQUENCE_TONE_SYNTH_MACROS_SVH
`define NOTE_SEQUENCE_TONE_SYNTH_MACROS_SVH

// Same-cycle implication, muted during reset
`define NSTS_CHECK_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nsts check failed");

// Next-cycle implication, muted during reset
`define NSTS_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nsts check failed");

`endif

// ===== rtl/nsts_pkg.sv =====
// Shared types, constants and constant tables of the tone synthesizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package nsts_pkg;

	// Core configuration
	localparam int SampleRate  = 44100;
	localparam int PhaseBits   = 32;
	localparam int SineBits    = 10;
	localparam int MaxOctShift = 3;

	// Field widths
	localparam int SymW    = 8;
	localparam int AmpW    = 15;
	localparam int SampleW = 16;
	localparam int SineFrac = 15;
	localparam int PeakReset = 10000;

	// Note length
	localparam int FullLen = 2 * SampleRate;
	localparam int LenW    = $clog2(FullLen + 1);
	localparam int LselW   = 3;
	localparam int SqW     = 2 * LenW;

	localparam logic [LselW-1:0] LSEL_WHOLE     = 3'd0;
	localparam logic [LselW-1:0] LSEL_HALF      = 3'd1;
	localparam logic [LselW-1:0] LSEL_QUARTER   = 3'd2;
	localparam logic [LselW-1:0] LSEL_EIGHTH    = 3'd3;
	localparam logic [LselW-1:0] LSEL_SIXTEENTH = 3'd4;

	// Octave shift and phase step
	localparam int OctW = $clog2(MaxOctShift + 1) + 1;
	localparam int ShW  = $clog2(2 * MaxOctShift + 2);
	localparam logic signed [OctW-1:0] OctMax = OctW'(MaxOctShift);
	localparam logic signed [OctW-1:0] OctMin = -OctMax;
	localparam int StepRW = PhaseBits + 8;
	localparam longint unsigned StepDen = 64'd800 * SampleRate;
	localparam int StepFracShift = PhaseBits + MaxOctShift + 4;

	// Pitch ratios: pitch (centihertz) scaled to the highest octave, one extra bit
	localparam logic [StepRW-1:0] PITCH_A  = StepRW'((64'd44000 << StepFracShift) / StepDen);
	localparam logic [StepRW-1:0] PITCH_B  = StepRW'((64'd49388 << StepFracShift) / StepDen);
	localparam logic [StepRW-1:0] PITCH_C  = StepRW'((64'd52325 << StepFracShift) / StepDen);
	localparam logic [StepRW-1:0] PITCH_D  = StepRW'((64'd58733 << StepFracShift) / StepDen);
	localparam logic [StepRW-1:0] PITCH_E  = StepRW'((64'd65926 << StepFracShift) / StepDen);
	localparam logic [StepRW-1:0] PITCH_F  = StepRW'((64'd69846 << StepFracShift) / StepDen);
	localparam logic [StepRW-1:0] PITCH_G  = StepRW'((64'd78399 << StepFracShift) / StepDen);
	localparam logic [StepRW-1:0] PITCH_AF = StepRW'((64'd41530 << StepFracShift) / StepDen);
	localparam logic [StepRW-1:0] PITCH_BF = StepRW'((64'd46616 << StepFracShift) / StepDen);
	localparam logic [StepRW-1:0] PITCH_DF = StepRW'((64'd55437 << StepFracShift) / StepDen);
	localparam logic [StepRW-1:0] PITCH_EF = StepRW'((64'd62225 << StepFracShift) / StepDen);
	localparam logic [StepRW-1:0] PITCH_GF = StepRW'((64'd73999 << StepFracShift) / StepDen);

	// Notation characters
	localparam logic [SymW-1:0] SYM_WHOLE     = "1";
	localparam logic [SymW-1:0] SYM_HALF      = "2";
	localparam logic [SymW-1:0] SYM_QUARTER   = "4";
	localparam logic [SymW-1:0] SYM_EIGHTH    = "8";
	localparam logic [SymW-1:0] SYM_SIXTEENTH = "6";
	localparam logic [SymW-1:0] SYM_UP        = "+";
	localparam logic [SymW-1:0] SYM_DOWN      = "-";
	localparam logic [SymW-1:0] SYM_REST      = ".";
	localparam logic [SymW-1:0] SYM_END       = "X";
	localparam logic [SymW-1:0] SYM_A  = "A";
	localparam logic [SymW-1:0] SYM_B  = "B";
	localparam logic [SymW-1:0] SYM_C  = "C";
	localparam logic [SymW-1:0] SYM_D  = "D";
	localparam logic [SymW-1:0] SYM_E  = "E";
	localparam logic [SymW-1:0] SYM_F  = "F";
	localparam logic [SymW-1:0] SYM_G  = "G";
	localparam logic [SymW-1:0] SYM_AF = "a";
	localparam logic [SymW-1:0] SYM_BF = "b";
	localparam logic [SymW-1:0] SYM_DF = "d";
	localparam logic [SymW-1:0] SYM_EF = "e";
	localparam logic [SymW-1:0] SYM_GF = "g";

	// Envelope divider and shared multiplier
	localparam int QuoBits = AmpW;
	localparam int CntW    = $clog2(QuoBits);
	localparam int MulAW   = SqW;
	localparam int MulBW   = LenW;
	localparam int ProdW   = MulAW + MulBW;

	// Quarter-wave sine table
	localparam int QuarterBits    = SineBits - 2;
	localparam int QuarterEntries = 1 << QuarterBits;
	localparam longint unsigned HalfPiQ30 = 64'd1686629713;

	typedef logic [AmpW-1:0] qsine_tab_t [QuarterEntries];

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPAN,
		ST_PEAK,
		ST_DIV,
		ST_SCALE,
		ST_WRITE
	} seq_state_t;

	// Shared unit operations
	typedef enum logic [2:0] {
		ALU_HOLD,
		ALU_SPAN,
		ALU_PEAK,
		ALU_DIV,
		ALU_SCALE
	} alu_op_t;

	// Note state seen by one tick
	typedef struct packed {
		logic                active;
		logic                last;
		logic                ended;
		logic [LselW-1:0]    lsel;
		logic [LenW-1:0]     idx;
		logic [SineBits-1:0] sidx;
	} note_snap_t;

	// Note length in samples for a length code, at least one
	function automatic logic [LenW-1:0] len_of(logic [LselW-1:0] lsel);
		logic [LenW-1:0] l;
		l = LenW'(FullLen) >> lsel;
		if (l == '0)
			l = LenW'(1);
		return l;
	endfunction

	// Squared note length, constant per code
	function automatic logic [SqW-1:0] len_sq_of(logic [LselW-1:0] lsel);
		logic [SqW-1:0] sq;
		case (lsel)
			LSEL_WHOLE:     sq = SqW'(64'(FullLen) * 64'(FullLen));
			LSEL_HALF:      sq = SqW'(64'(FullLen >> 1) * 64'(FullLen >> 1));
			LSEL_QUARTER:   sq = SqW'(64'(FullLen >> 2) * 64'(FullLen >> 2));
			LSEL_EIGHTH:    sq = SqW'(64'(FullLen >> 3) * 64'(FullLen >> 3));
			LSEL_SIXTEENTH: sq = SqW'(64'(FullLen >> 4) * 64'(FullLen >> 4));
			default:        sq = SqW'(1);
		endcase
		return sq;
	endfunction

	// Q15 magnitude of sin(pi/2 * q / QuarterEntries) from a six-term Q30 series
	function automatic logic [AmpW-1:0] quarter_sine(int unsigned q);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned v;
		longint s;
		x  = (HalfPiQ30 * q + QuarterEntries / 2) >> QuarterBits;
		x2 = (x * x) >> 30;
		// Each term is the previous one times x^2 over (2n)(2n+1)
		t  = ((x * x2) >> 30) / 64'd6;
		s  = longint'(x) - longint'(t);
		t  = ((t * x2) >> 30) / 64'd20;
		s  = s + longint'(t);
		t  = ((t * x2) >> 30) / 64'd42;
		s  = s - longint'(t);
		t  = ((t * x2) >> 30) / 64'd72;
		s  = s + longint'(t);
		t  = ((t * x2) >> 30) / 64'd110;
		s  = s - longint'(t);
		if (s < 0)
			s = 0;
		v = s;
		v = (v * 32767 + (64'd1 << 29)) >> 30;
		if (v > 32767)
			v = 32767;
		return AmpW'(v);
	endfunction

	function automatic qsine_tab_t build_qsine_tab();
		qsine_tab_t tab;
		for (int k = 0; k < QuarterEntries; k++)
			tab[k] = quarter_sine(k);
		return tab;
	endfunction

	localparam qsine_tab_t QSineTab = build_qsine_tab();
	localparam logic [AmpW-1:0] QSineTop = quarter_sine(QuarterEntries);

endpackage

// ===== rtl/nsts_sine.sv =====
// Sine magnitude and sign lookup through the quarter-wave table.
// Depends on nsts_pkg (table and widths).
`timescale 1ns / 1ps

module nsts_sine import nsts_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [SineBits-1:0] sidx,
	output logic [AmpW-1:0]     smag,
	output logic                neg
);

	logic [1:0]             quad;
	logic [QuarterBits-1:0] j;
	logic [QuarterBits-1:0] j_mirror;
	logic [AmpW-1:0]        mag_d;

	// Quadrant split: odd quadrants read mirrored, upper half is negative
	assign quad     = sidx[SineBits-1 -: 2];
	assign j        = sidx[QuarterBits-1:0];
	assign j_mirror = QuarterBits'(0) - j;

	always_comb begin
		if (!quad[0])
			mag_d = QSineTab[j];
		else if (j == '0)
			mag_d = QSineTop;
		else
			mag_d = QSineTab[j_mirror];
	end

	// Registered at tick accept, held for the rest of the item
	always_ff @(posedge clk) begin
		if (en) begin
			smag <= mag_d;
			neg  <= quad[1];
		end
	end

endmodule

// ===== rtl/nsts_alu.sv =====
// Shared datapath: one multiplier plus one compare-subtract for the envelope.
// Depends on nsts_pkg (alu_op_t, widths).
`timescale 1ns / 1ps

module nsts_alu import nsts_pkg::*; (
	input  logic             clk,
	input  alu_op_t          op,
	input  logic [LenW-1:0]  idx,
	input  logic [LenW-1:0]  len,
	input  logic [SqW-1:0]   len_sq,
	input  logic [AmpW-1:0]  peak,
	input  logic [AmpW-1:0]  smag,
	output logic [AmpW-1:0]  mag
);

	logic [ProdW-1:0]   acc_q;
	logic [ProdW-1:0]   dvs_q;
	logic [QuoBits-1:0] quo_q;

	logic [MulAW-1:0]   mul_a;
	logic [MulBW-1:0]   mul_b;
	logic [ProdW-1:0]   prod;
	logic               ge;
	logic [ProdW-1:0]   diff;
	logic [AmpW-1:0]    envmag;

	// Ceiling of the quotient: bump when the remainder is nonzero
	assign envmag = quo_q + AmpW'(acc_q != '0);

	// Operand select for the shared multiplier
	always_comb begin
		case (op)
			ALU_SPAN: begin
				mul_a = MulAW'(idx);
				mul_b = len - idx;
			end
			ALU_PEAK: begin
				mul_a = acc_q[MulAW-1:0];
				mul_b = MulBW'(peak);
			end
			ALU_SCALE: begin
				mul_a = MulAW'(envmag);
				mul_b = MulBW'(smag);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = ProdW'(mul_a) * ProdW'(mul_b);

	// Restoring division step
	assign ge   = acc_q >= dvs_q;
	assign diff = acc_q - dvs_q;

	always_ff @(posedge clk) begin
		case (op)
			ALU_SPAN: acc_q <= prod;
			ALU_PEAK: begin
				// 4*peak*i*(L-i), divisor aligned to the top quotient bit
				acc_q <= {prod[ProdW-3:0], 2'b00};
				dvs_q <= ProdW'(len_sq) << (QuoBits - 1);
				quo_q <= '0;
			end
			ALU_DIV: begin
				if (ge)
					acc_q <= diff;
				quo_q <= {quo_q[QuoBits-2:0], ge};
				dvs_q <= dvs_q >> 1;
			end
			ALU_SCALE: acc_q <= prod;
			default: ;
		endcase
	end

	// Q15 scale; envelope and sine are both below 2^15, so no clamp is needed
	assign mag = acc_q[SineFrac +: AmpW];

endmodule

// ===== rtl/nsts_note.sv =====
// Notation decoder and note state: length, octave, phase and sample index.
// Depends on nsts_pkg (symbol codes, pitch ratios, note_snap_t).
`timescale 1ns / 1ps

module nsts_note import nsts_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            chr_en,
	input  logic [SymW-1:0] symbol,
	input  logic            tick_en,
	output note_snap_t      snap
);

	logic [LselW-1:0]            lsel_q;
	logic signed [OctW-1:0]      oct_q;
	logic [LselW-1:0]            note_lsel_q;
	logic [LenW-1:0]             idx_q;
	logic [PhaseBits-1:0]        phase_q;
	logic [PhaseBits-1:0]        step_q;
	logic                        active_q;
	logic                        ended_q;

	logic                        lsel_set;
	logic [LselW-1:0]            lsel_d;
	logic                        oct_up;
	logic                        oct_dn;
	logic                        start;
	logic                        end_set;
	logic [StepRW-1:0]           ratio;
	logic signed [OctW:0]        mdiff;
	logic [ShW-1:0]              m;
	logic [ShW:0]                sh1;
	logic [StepRW-1:0]           step_wide;
	logic [PhaseBits-1:0]        step_new;
	logic [LenW-1:0]             len;
	logic [LenW-1:0]             idx_next;

	// Character decode
	always_comb begin
		lsel_set = 1'b0;
		lsel_d   = lsel_q;
		oct_up   = 1'b0;
		oct_dn   = 1'b0;
		start    = 1'b0;
		end_set  = 1'b0;
		ratio    = '0;
		unique case (symbol)
			SYM_WHOLE:     begin lsel_set = 1'b1; lsel_d = LSEL_WHOLE;     end
			SYM_HALF:      begin lsel_set = 1'b1; lsel_d = LSEL_HALF;      end
			SYM_QUARTER:   begin lsel_set = 1'b1; lsel_d = LSEL_QUARTER;   end
			SYM_EIGHTH:    begin lsel_set = 1'b1; lsel_d = LSEL_EIGHTH;    end
			SYM_SIXTEENTH: begin lsel_set = 1'b1; lsel_d = LSEL_SIXTEENTH; end
			SYM_UP:        oct_up  = 1'b1;
			SYM_DOWN:      oct_dn  = 1'b1;
			SYM_REST:      start   = 1'b1;
			SYM_END:       end_set = 1'b1;
			SYM_A:  begin start = 1'b1; ratio = PITCH_A;  end
			SYM_B:  begin start = 1'b1; ratio = PITCH_B;  end
			SYM_C:  begin start = 1'b1; ratio = PITCH_C;  end
			SYM_D:  begin start = 1'b1; ratio = PITCH_D;  end
			SYM_E:  begin start = 1'b1; ratio = PITCH_E;  end
			SYM_F:  begin start = 1'b1; ratio = PITCH_F;  end
			SYM_G:  begin start = 1'b1; ratio = PITCH_G;  end
			SYM_AF: begin start = 1'b1; ratio = PITCH_AF; end
			SYM_BF: begin start = 1'b1; ratio = PITCH_BF; end
			SYM_DF: begin start = 1'b1; ratio = PITCH_DF; end
			SYM_EF: begin start = 1'b1; ratio = PITCH_EF; end
			SYM_GF: begin start = 1'b1; ratio = PITCH_GF; end
			default: ;
		endcase
	end

	// Phase step: round the top-octave ratio down by the octave distance.
	// A rest has ratio zero, which rounds to a zero step.
	assign mdiff     = (OctW + 1)'(MaxOctShift) - {oct_q[OctW-1], oct_q};
	assign m         = ShW'(mdiff);
	assign sh1       = {1'b0, m} + (ShW + 1)'(1);
	assign step_wide = (ratio + (StepRW'(1) << m)) >> sh1;
	assign step_new  = step_wide[PhaseBits-1:0];

	assign len      = len_of(note_lsel_q);
	assign idx_next = idx_q + LenW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsel_q      <= LSEL_WHOLE;
			oct_q       <= '0;
			note_lsel_q <= LSEL_WHOLE;
			idx_q       <= '0;
			phase_q     <= '0;
			step_q      <= '0;
			active_q    <= 1'b0;
			ended_q     <= 1'b0;
		end else if (chr_en) begin
			if (!ended_q) begin
				if (lsel_set)
					lsel_q <= lsel_d;
				if (oct_up && oct_q < OctMax)
					oct_q <= oct_q + OctW'(1);
				if (oct_dn && oct_q > OctMin)
					oct_q <= oct_q - OctW'(1);
				if (start) begin
					note_lsel_q <= lsel_q;
					idx_q       <= '0;
					phase_q     <= '0;
					step_q      <= step_new;
					active_q    <= 1'b1;
				end
				if (end_set)
					ended_q <= 1'b1;
			end
		end else if (tick_en && active_q) begin
			// Advance after this tick's sample values are taken
			phase_q <= phase_q + step_q;
			idx_q   <= idx_next;
			if (idx_next >= len)
				active_q <= 1'b0;
		end
	end

	// Values for the current tick
	always_comb begin
		snap.active = active_q;
		snap.last   = active_q && (idx_next >= len);
		snap.ended  = ended_q;
		snap.lsel   = note_lsel_q;
		snap.idx    = idx_q;
		snap.sidx   = phase_q[PhaseBits-1 -: SineBits];
	end

endmodule

// ===== rtl/note_sequence_tone_synth.sv =====
// Top level of the tone synthesizer: sequencer, peak register and result register.
// Depends on nsts_pkg, nsts_note, nsts_sine, nsts_alu and the assertion macros.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in      | sink      | in_valid / in_stall  | command, symbol
//  out     | source    | out_valid / out_stall| sample, playing, note_last, song_ended
//  cfg     | sink      | cfg_valid / cfg_ready| cfg_data (peak amplitude)
//
// A character beat is taken without stalling the input and gives no result.
// A tick of a sounding note or rest runs, after accept, through span multiply,
// peak multiply, 15 restoring divide steps, sine scale and result write, all on the
// shared multiplier and subtractor. An idle tick goes from accept straight to the write.
// in_stall is high from tick accept until the result is written to the output
// register; a stalled output holds the sequencer in its write state.
// Reset clears all note state; cfg_ready is always high.
`timescale 1ns / 1ps

`include "note_sequence_tone_synth_macros.svh"

module note_sequence_tone_synth import nsts_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      command,
	input  logic [SymW-1:0]           symbol,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [SampleW-1:0] sample,
	output logic                      playing,
	output logic                      note_last,
	output logic                      song_ended,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [AmpW-1:0]           cfg_data
);

	seq_state_t          state_q;
	seq_state_t          state_d;
	logic [CntW-1:0]     div_cnt_q;
	logic [AmpW-1:0]     peak_q;
	note_snap_t          snap;
	note_snap_t          snap_q;
	alu_op_t             op;
	logic                tick_acc;
	logic                chr_acc;
	logic                out_load;
	logic [AmpW-1:0]     smag;
	logic                neg;
	logic [AmpW-1:0]     mag;
	logic                out_valid_q;
	logic [SampleW-1:0]  sample_q;
	logic                playing_q;
	logic                last_q;
	logic                ended_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign tick_acc  = in_valid && !in_stall && command;
	assign chr_acc   = in_valid && !in_stall && !command;
	assign cfg_ready = 1'b1;

	// Peak amplitude register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			peak_q <= AmpW'(PeakReset);
		else if (cfg_valid && cfg_ready)
			peak_q <= cfg_data;
	end

	nsts_note u_note (
		.clk     (clk),
		.arst_n  (arst_n),
		.chr_en  (chr_acc),
		.symbol  (symbol),
		.tick_en (tick_acc),
		.snap    (snap)
	);

	nsts_sine u_sine (
		.clk  (clk),
		.en   (tick_acc),
		.sidx (snap.sidx),
		.smag (smag),
		.neg  (neg)
	);

	nsts_alu u_alu (
		.clk    (clk),
		.op     (op),
		.idx    (snap_q.idx),
		.len    (len_of(snap_q.lsel)),
		.len_sq (len_sq_of(snap_q.lsel)),
		.peak   (peak_q),
		.smag   (smag),
		.mag    (mag)
	);

	// Tick snapshot, taken before the note state advances
	always_ff @(posedge clk) begin
		if (tick_acc)
			snap_q <= snap;
	end

	// Sequencer state and divide step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PEAK)
				div_cnt_q <= '0;
			else if (state_q == ST_DIV)
				div_cnt_q <= div_cnt_q + CntW'(1);
		end
	end

	// Next state and unit control
	always_comb begin
		state_d  = state_q;
		op       = ALU_HOLD;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (tick_acc)
					state_d = snap.active ? ST_SPAN : ST_WRITE;
			end
			ST_SPAN: begin
				op      = ALU_SPAN;
				state_d = ST_PEAK;
			end
			ST_PEAK: begin
				op      = ALU_PEAK;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				op = ALU_DIV;
				if (div_cnt_q == CntW'(QuoBits - 1))
					state_d = ST_SCALE;
			end
			ST_SCALE: begin
				op      = ALU_SCALE;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			// Envelope is a magnitude; the sample takes the sign opposite to the sine
			if (!snap_q.active)
				sample_q <= '0;
			else if (neg)
				sample_q <= {1'b0, mag};
			else
				sample_q <= SampleW'(0) - {1'b0, mag};
			playing_q <= snap_q.active;
			last_q    <= snap_q.last;
			ended_q   <= snap_q.ended;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample     = sample_q;
	assign playing    = playing_q;
	assign note_last  = last_q;
	assign song_ended = ended_q;

	// Checks
	`NSTS_CHECK_NEXT(a_busy_after_tick, tick_acc, in_stall)
	`NSTS_CHECK_NEXT(a_write_holds, (state_q == ST_WRITE) && out_valid && out_stall, state_q == ST_WRITE)
	`NSTS_CHECK_NOW(a_silent_idle, out_valid && !playing, (sample == '0) && !note_last)
	`NSTS_CHECK_NOW(a_div_count, state_q == ST_DIV, div_cnt_q < CntW'(QuoBits))

endmodule

// ===== tb/sv/tb_note_sequence_tone_synth.sv =====
// Self-checking testbench of note_sequence_tone_synth: a tracker class predicts each
// tick sample from the accepted beats, plain tasks drive and pace the three channels.
// Depends on nsts_pkg and the note_sequence_tone_synth RTL.
`timescale 1ns / 1ps

module tb_note_sequence_tone_synth;
	import nsts_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int LONG_HOLD      = 400;
	localparam int CHUNK_ITEMS    = 300;
	localparam int QTR            = 1 << (SineBits - 2);
	localparam int END_LEAD_TICKS = 60;
	localparam int END_TAIL_TICKS = 40;

	localparam logic CMD_CHAR = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [SymW-1:0] LEN_SYMS [5] = '{SYM_WHOLE, SYM_HALF, SYM_QUARTER,
		SYM_EIGHTH, SYM_SIXTEENTH};
	localparam logic [SymW-1:0] SOUND_SYMS [13] = '{SYM_A, SYM_B, SYM_C, SYM_D, SYM_E,
		SYM_F, SYM_G, SYM_AF, SYM_BF, SYM_DF, SYM_EF, SYM_GF, SYM_REST};

	typedef struct {
		logic signed [SampleW-1:0] sample;
		bit playing;
		bit last;
		bit ended;
	} tone_result_t;

	// Tone tracker: note state, peak setting and the samples still owed by the block
	class tone_tracker;
		int unsigned qwave [QTR + 1];
		logic [AmpW-1:0] peak;
		logic [LselW-1:0] length_sel;
		int octave;
		int unsigned note_len;
		int unsigned index;
		logic [PhaseBits-1:0] phase;
		logic [PhaseBits-1:0] step;
		bit active;
		bit ended;
		tone_result_t expected_samples [$];
		int unsigned errors;
		int unsigned ticks_checked;

		function new();
			for (int q = 0; q <= QTR; q++)
				qwave[q] = quarter_wave(q);
			peak = 15'd10000;
			length_sel = LSEL_WHOLE;
			octave = 0;
			note_len = 0;
			index = 0;
			phase = '0;
			step = '0;
			active = 1'b0;
			ended = 1'b0;
			errors = 0;
			ticks_checked = 0;
		endfunction

		// Q15 quarter-wave magnitude from a six-term Q30 Taylor series
		function int unsigned quarter_wave(int unsigned q);
			longint unsigned x;
			longint unsigned x2;
			longint unsigned t;
			longint unsigned v;
			longint acc;
			x = (64'd1686629713 * q + QTR / 2) / QTR;
			x2 = (x * x) >> 30;
			t = x;
			acc = longint'(x);
			for (int n = 1; n <= 5; n++) begin
				t = ((t * x2) >> 30) / ((2 * n) * (2 * n + 1));
				if (n % 2 == 1)
					acc -= longint'(t);
				else
					acc += longint'(t);
			end
			if (acc < 0)
				acc = 0;
			v = acc;
			v = (v * 32767 + (64'd1 << 29)) >> 30;
			if (v > 32767)
				v = 32767;
			return int'(v);
		endfunction

		// Full-wave sine through quarter-wave symmetry
		function int sine_at(logic [PhaseBits-1:0] ph);
			int unsigned k;
			k = ph[PhaseBits-1 -: SineBits];
			if (k < QTR)
				return qwave[k];
			if (k < 2 * QTR)
				return qwave[2 * QTR - k];
			if (k < 3 * QTR)
				return -int'(qwave[k - 2 * QTR]);
			return -int'(qwave[4 * QTR - k]);
		endfunction

		// Pitch in centihertz, zero for anything that is not a note
		function int unsigned pitch_of(logic [SymW-1:0] sym);
			case (sym)
				SYM_A:   return 44000;
				SYM_B:   return 49388;
				SYM_C:   return 52325;
				SYM_D:   return 58733;
				SYM_E:   return 65926;
				SYM_F:   return 69846;
				SYM_G:   return 78399;
				SYM_AF:  return 41530;
				SYM_BF:  return 46616;
				SYM_DF:  return 55437;
				SYM_EF:  return 62225;
				SYM_GF:  return 73999;
				default: return 0;
			endcase
		endfunction

		function bit is_notation(logic [SymW-1:0] sym);
			case (sym)
				SYM_WHOLE, SYM_HALF, SYM_QUARTER, SYM_EIGHTH, SYM_SIXTEENTH,
				SYM_UP, SYM_DOWN, SYM_REST, SYM_END: return 1'b1;
				default: return pitch_of(sym) != 0;
			endcase
		endfunction

		// Note or rest start; the step is rounded and wraps at the phase width
		function void start_sound(int unsigned fc);
			longint unsigned num;
			longint unsigned den;
			note_len = (2 * SampleRate) >> length_sel;
			if (note_len == 0)
				note_len = 1;
			index = 0;
			phase = '0;
			active = 1'b1;
			if (fc == 0) begin
				step = '0;
			end else begin
				num = longint'(fc) << (PhaseBits + 3 + octave);
				den = 64'd800 * SampleRate;
				step = PhaseBits'((num + den / 2) / den);
			end
		endfunction

		function void apply_symbol(logic [SymW-1:0] sym);
			int unsigned fc;
			if (ended)
				return;
			case (sym)
				SYM_WHOLE:     length_sel = LSEL_WHOLE;
				SYM_HALF:      length_sel = LSEL_HALF;
				SYM_QUARTER:   length_sel = LSEL_QUARTER;
				SYM_EIGHTH:    length_sel = LSEL_EIGHTH;
				SYM_SIXTEENTH: length_sel = LSEL_SIXTEENTH;
				SYM_UP:        if (octave < MaxOctShift) octave++;
				SYM_DOWN:      if (octave > -MaxOctShift) octave--;
				SYM_REST:      start_sound(0);
				SYM_END:       ended = 1'b1;
				default: begin
					fc = pitch_of(sym);
					if (fc != 0)
						start_sound(fc);
				end
			endcase
		endfunction

		// One sample: sine times the parabolic envelope, then advance the note
		function void predict_tick();
			tone_result_t r;
			longint unsigned len;
			longint unsigned l2;
			longint unsigned m;
			longint unsigned env;
			longint unsigned mag;
			int s;
			int unsigned smag;
			int value;
			r.sample = '0;
			r.playing = 1'b0;
			r.last = 1'b0;
			r.ended = ended;
			if (active) begin
				len = note_len;
				l2 = len * len;
				m = 64'd4 * peak * index * (len - index);
				env = (m + l2 - 1) / l2;
				s = sine_at(phase);
				smag = (s < 0) ? -s : s;
				mag = (env * smag) >> 15;
				if (mag > 32767)
					mag = 32767;
				// env is a magnitude; the sample has the sine's opposite sign
				value = (s < 0) ? int'(mag) : -int'(mag);
				r.sample = SampleW'(value);
				r.playing = 1'b1;
				phase += step;
				index++;
				if (index >= len) begin
					r.last = 1'b1;
					active = 1'b0;
				end
			end
			expected_samples.push_back(r);
		endfunction

		function void note_beat(logic cmd, logic [SymW-1:0] sym);
			if (cmd == CMD_TICK)
				predict_tick();
			else
				apply_symbol(sym);
		endfunction

		function void check_result(logic signed [SampleW-1:0] got_sample, logic got_playing,
				logic got_last, logic got_ended);
			tone_result_t e;
			if (expected_samples.size() == 0) begin
				$error("result with nothing expected: sample %0d playing %0b",
					got_sample, got_playing);
				errors++;
				return;
			end
			e = expected_samples.pop_front();
			ticks_checked++;
			if (got_sample !== e.sample) begin
				$error("sample: expected %0d, got %0d", e.sample, got_sample);
				errors++;
			end
			if (got_playing !== e.playing) begin
				$error("playing: expected %0b, got %0b", e.playing, got_playing);
				errors++;
			end
			if (got_last !== e.last) begin
				$error("note_last: expected %0b, got %0b", e.last, got_last);
				errors++;
			end
			if (got_ended !== e.ended) begin
				$error("song_ended: expected %0b, got %0b", e.ended, got_ended);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = CMD_CHAR;
	logic [SymW-1:0] symbol = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SampleW-1:0] sample;
	logic playing;
	logic note_last;
	logic song_ended;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [AmpW-1:0] cfg_data = '0;

	tone_tracker tracker = new();
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int hold_requests = 0;
	int holds_done = 0;
	int beats_counted = 0;
	int beats_total = 0;
	int quiet_cycles = 0;

	always #4 clk = ~clk;

	note_sequence_tone_synth DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.symbol     (symbol),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample     (sample),
		.playing    (playing),
		.note_last  (note_last),
		.song_ended (song_ended),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	// One input beat, after a random number of idle cycles; valid stays up afterwards
	task automatic send_beat(logic cmd, logic [SymW-1:0] sym);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		symbol <= sym;
		do @(posedge clk); while (in_stall);
		if (cmd == CMD_TICK || tracker.is_notation(sym))
			beats_counted++;
		beats_total++;
	endtask

	// Symbol is a don't-care on ticks, so it carries random bits
	task automatic send_tick();
		send_beat(CMD_TICK, SymW'($urandom));
	endtask

	task automatic write_peak(logic [AmpW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, wait for every owed sample, then wait out DRAIN_CYCLES
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.expected_samples.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Receiver: random stall, or a long hold-off when one is requested
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_requests != holds_done) begin
				holds_done++;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < sink_stall_pct);
		end
	end

	// Beat monitor and watchdog
	always @(posedge clk) begin : monitor
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.peak = cfg_data;
			if (in_valid && !in_stall)
				tracker.note_beat(command, symbol);
			if (out_valid && !out_stall)
				tracker.check_result(sample, playing, note_last, song_ended);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$error("no beat moved for %0d cycles", quiet_cycles);
				$display("tb_note_sequence_tone_synth NOT OK");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [SymW-1:0] noise;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle tick, ignored byte extremes, notes at both octave limits, a rest
		send_tick();
		send_beat(CMD_CHAR, 8'h00);
		send_beat(CMD_CHAR, 8'hFF);
		send_beat(CMD_CHAR, SYM_SIXTEENTH);
		send_beat(CMD_CHAR, SYM_A);
		repeat (2) send_tick();
		repeat (4) send_beat(CMD_CHAR, SYM_UP);
		send_beat(CMD_CHAR, SYM_G);
		send_tick();
		repeat (7) send_beat(CMD_CHAR, SYM_DOWN);
		send_beat(CMD_CHAR, SYM_AF);
		send_tick();
		send_beat(CMD_CHAR, SYM_REST);
		send_tick();
		settle();

		// Random phrases over six peak settings and three pacing modes
		for (int c = 0; c < 6; c++) begin
			case (c)
				0:       write_peak('0);
				2:       write_peak('1);
				4:       write_peak(AmpW'(1));
				default: write_peak(AmpW'($urandom));
			endcase
			src_idle_pct = (c < 2) ? 31 : (c < 4) ? 50 : 0;
			sink_stall_pct = (c < 2) ? 50 : (c < 4) ? 31 : 0;
			if (c == 2)
				hold_requests <= hold_requests + 1;
			beats_counted = 0;
			while (beats_counted < CHUNK_ITEMS) begin
				if ($urandom_range(99) < 15) begin
					// noise beat; the end character is kept for the last phase
					noise = SymW'($urandom);
					if (noise == SYM_END)
						noise = SYM_REST;
					send_beat(1'($urandom), noise);
				end else begin
					if ($urandom_range(2) == 0)
						send_beat(CMD_CHAR, LEN_SYMS[$urandom_range(4)]);
					repeat ($urandom_range(2))
						send_beat(CMD_CHAR, $urandom_range(1) ? SYM_UP : SYM_DOWN);
					send_beat(CMD_CHAR, SOUND_SYMS[$urandom_range(12)]);
					repeat ($urandom_range(12, 1)) send_tick();
				end
			end
			settle();
		end

		// Sixteenth note at top peak, song end mid-note, ignored characters after it
		write_peak('1);
		send_beat(CMD_CHAR, SYM_SIXTEENTH);
		send_beat(CMD_CHAR, SYM_E);
		repeat (END_LEAD_TICKS) send_tick();
		send_beat(CMD_CHAR, SYM_END);
		for (int k = 0; k < END_TAIL_TICKS; k++) begin
			if ($urandom_range(3) == 0)
				send_beat(CMD_CHAR, $urandom_range(1) ? SYM_C : SymW'($urandom));
			send_tick();
		end
		settle();

		$display("Covered %0d beats and %0d checked samples: directed extremes, six peaks",
			beats_total, tracker.ticks_checked);
		$display("with both pacing mixes, a long output hold and a note cut by the song end.");
		if (tracker.errors == 0 && tracker.expected_samples.size() == 0)
			$display("tb_note_sequence_tone_synth OK");
		else
			$display("tb_note_sequence_tone_synth NOT OK");
		$finish;
	end

endmodule
